FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the list RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ALI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition must never be seen outside reset.
`define ALI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ALI_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/core/ali_pkg.sv
// Shared types and field widths for the array list block.
// No dependencies.
`default_nettype none

package ali_pkg;

	localparam int unsigned ACT_W  = 3;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned CNT_W  = 7;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_DELETE = 3'd1,
		ACT_GET    = 3'd2,
		ACT_SET    = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NOPOS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FETCH,
		ST_RD,
		ST_WR,
		ST_LAST,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/array_list_insert_delete.sv
// Ordered list of signed 32-bit values with shifting insert and delete.
// Depends on ali_pkg, ali_store and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries action, position, value.
//    in_ready is high only while the sequencer is idle; one transaction is
//    worked on at a time.
//  - Output channel (out_valid/out_ready) carries read_value, status, count,
//    one result per input transaction, held in an output register.
//  - After accept, each action is decoded; an insert then shifts entries
//    from the top down to position and writes the new value (an append
//    only writes it); a delete fetches the entry, shifts those above it
//    down and zeroes the old top slot; get fetches the entry; set, clear
//    and rejects go straight to done. Each shifted entry is a read and a
//    write on split store ports, stepped by one shared index adder/comparator.
//  - Receiver stall: a finished result waits in the output register; the
//    sequencer may take and work the next transaction, then holds in its
//    final state until the output register frees up.
//  - Reset (arst_n low): list empties, store reads as all zero through
//    per-entry valid bits, output channel goes idle. No clearing pass.
`default_nettype none

`include "assert_macros.svh"

module array_list_insert_delete #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic        [ali_pkg::ACT_W-1:0]   action,
	input  wire logic        [ali_pkg::POS_W-1:0]   position,
	input  wire logic signed [ali_pkg::VAL_W-1:0]   value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed      [ali_pkg::VAL_W-1:0]   read_value,
	output logic             [ali_pkg::STAT_W-1:0]  status,
	output logic             [ali_pkg::CNT_W-1:0]   count
);
	import ali_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	// common compare width for position, count and index
	localparam int unsigned EW = (CW > CNT_W) ? CW : CNT_W;

	state_t state_q, state_d;

	// captured transaction
	action_t          act_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;

	// working state
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic [VAL_W-1:0] rd_q;
	status_t          stat_q;

	// output register
	logic             out_valid_q;
	logic [VAL_W-1:0] out_rd_q;
	status_t          out_stat_q;
	logic [CNT_W-1:0] out_cnt_q;

	// store port
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [VAL_W-1:0] mem_wdata, mem_rdata;

	// shared index unit
	logic [CW-1:0] idx_step;
	logic [EW-1:0] pos_e, cnt_e, idx_e, step_e, cnt_m1;
	logic          full, in_range, ins_move, del_ok, del_more, more, done_go;

	always_comb begin
		idx_step = (act_q == ACT_INSERT) ? idx_q - CW'(1) : idx_q + CW'(1);
		pos_e    = EW'(pos_q);
		cnt_e    = EW'(cnt_q);
		idx_e    = EW'(idx_q);
		step_e   = EW'(idx_step);
		cnt_m1   = cnt_e - EW'(1);
		full     = cnt_e >= EW'(DEPTH);
		in_range = pos_e < EW'(DEPTH);
		ins_move = cnt_e > pos_e;
		del_ok   = pos_e < cnt_e;
		del_more = idx_e < cnt_m1;
		// insert walks down to position, delete walks up to count - 1
		more     = (act_q == ACT_INSERT) ? (step_e > pos_e) : (step_e < cnt_m1);
		done_go  = !out_valid_q || out_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (act_q)
					ACT_INSERT: begin
						if (full) begin
							state_d = ST_DONE;
						end else if (ins_move) begin
							state_d = ST_RD;
						end else begin
							state_d = ST_LAST;
						end
					end
					ACT_DELETE: state_d = del_ok ? ST_FETCH : ST_DONE;
					ACT_GET:    state_d = in_range ? ST_FETCH : ST_DONE;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_FETCH: begin
				if (act_q == ACT_DELETE) begin
					state_d = del_more ? ST_RD : ST_LAST;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RD:   state_d = ST_WR;
			ST_WR:   state_d = more ? ST_RD : ST_LAST;
			ST_LAST: state_d = ST_DONE;
			ST_DONE: begin
				if (done_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = pos_e[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = val_q;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DECODE: begin
				mem_re    = ((act_q == ACT_DELETE) && del_ok) ||
				            ((act_q == ACT_GET) && in_range);
				mem_we    = (act_q == ACT_SET) && in_range;
				mem_waddr = pos_e[AW-1:0];
			end
			ST_RD: begin
				mem_re    = 1'b1;
				mem_raddr = idx_step[AW-1:0];
			end
			ST_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			ST_LAST: begin
				// insert drops the new value in; delete zeroes the old top slot
				mem_we    = 1'b1;
				mem_wdata = (act_q == ACT_INSERT) ? val_q : '0;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DECODE) && (act_q == ACT_CLEAR)) begin
				cnt_q <= '0;
			end else if (state_q == ST_LAST) begin
				cnt_q <= (act_q == ACT_INSERT) ? cnt_q + CW'(1) : cnt_q - CW'(1);
			end
			if ((state_q == ST_DONE) && done_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					act_q <= action_t'(action);
					pos_q <= position;
					val_q <= value;
				end
			end
			ST_DECODE: begin
				rd_q  <= '0;
				idx_q <= (act_q == ACT_INSERT) ? cnt_q : CW'(pos_e);
				if ((act_q == ACT_INSERT) && full) begin
					stat_q <= STAT_FULL;
				end else if ((act_q == ACT_DELETE) && !del_ok) begin
					stat_q <= STAT_NOPOS;
				end else begin
					stat_q <= STAT_OK;
				end
			end
			ST_FETCH: rd_q  <= mem_rdata;
			ST_WR:    idx_q <= idx_step;
			ST_DONE: begin
				if (done_go) begin
					out_rd_q   <= rd_q;
					out_stat_q <= stat_q;
					out_cnt_q  <= cnt_e[CNT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	ali_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	assign out_valid  = out_valid_q;
	assign read_value = out_rd_q;
	assign status     = out_stat_q;
	assign count      = out_cnt_q;

	`ALI_ASSERT(a_accept_decode, clk, arst_n, in_valid && in_ready |=> state_q == ST_DECODE, "accepted transaction did not reach decode")
	`ALI_ASSERT_NEVER(a_cnt_range, clk, arst_n, EW'(cnt_q) > EW'(DEPTH), "entry count above depth")
	`ALI_ASSERT_NEVER(a_we_state, clk, arst_n, mem_we && !(state_q == ST_DECODE || state_q == ST_WR || state_q == ST_LAST), "store write outside a write state")
	`ALI_ASSERT(a_ins_count, clk, arst_n, state_q == ST_LAST && act_q == ACT_INSERT |=> cnt_q == $past(cnt_q) + CW'(1), "insert did not bump count")

endmodule

`default_nettype wire

FILE: rtl/core/ali_store.sv
// Entry store: one write port, one registered read port, per-entry valid bits.
// Depends on ali_pkg. Entries never written read as zero.
`default_nettype none

module ali_store #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [ali_pkg::VAL_W-1:0]  wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [ali_pkg::VAL_W-1:0]  rdata
);
	import ali_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [VAL_W-1:0] rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// valid bits stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire
